// ===== rtl/clce_pkg.sv =====
// Package: shared constants, codes and controller/datapath types for the list cursor engine.
`default_nettype none

package clce_pkg;

  localparam int NODES     = 256;
  localparam int WORD_BITS = 32;
  localparam int NODE_BITS = $clog2(NODES);
  localparam int CNT_BITS  = NODE_BITS + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Command codes on the input channel
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_LAST_OUT = 2'd3
  } status_t;

  // Operation class, decided when a transaction is accepted
  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LINK  = 3'd1,
    OP_INS_FULL  = 3'd2,
    OP_RM_EMPTY  = 3'd3,
    OP_RM_LAST   = 3'd4,
    OP_RM_LINK   = 3'd5
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic rd;      // issue link and free stack reads at the cursor
    logic link;    // first write phase
    logic commit;  // second write phase, state update, result load
    op_t  op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic single;
    logic can_alloc;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/clce_if.sv =====
// Interfaces: valid/ready channels for commands in and results out.
`default_nettype none

interface clce_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  clce_pkg::word_t word_in;

  modport source (output valid, output cmd, output word_in, input ready);
  modport sink   (input valid, input cmd, input word_in, output ready);
endinterface

interface clce_out_if;
  logic              valid;
  logic              ready;
  clce_pkg::word_t   current_word;
  logic              list_empty;
  clce_pkg::status_t status;
  clce_pkg::cnt_t    entry_count;

  modport source (output valid, output current_word, output list_empty, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input current_word, input list_empty, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/clce_ctrl.sv =====
// Controller: sequences each transaction through read, link and commit phases.
`default_nettype none

module clce_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire clce_pkg::dp_stat_t stat,
  output clce_pkg::dp_cmd_t       dcmd
);
  import clce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LINK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  op_t    op, op_dec;
  logic   fire;
  logic   commit;

  // No transaction is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign fire     = in_valid && in_ready;
  assign commit   = (state == S_FIN) && (!out_valid || out_ready);

  // Classify the incoming transaction from the current list status
  always_comb begin
    if (in_cmd == CMD_INSERT) begin
      if (!stat.can_alloc)  op_dec = OP_INS_FULL;
      else if (stat.empty)  op_dec = OP_INS_FIRST;
      else                  op_dec = OP_INS_LINK;
    end else begin
      if (stat.empty)       op_dec = OP_RM_EMPTY;
      else if (stat.single) op_dec = OP_RM_LAST;
      else                  op_dec = OP_RM_LINK;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (fire) state_next = S_LINK;
      S_LINK: state_next = S_FIN;
      S_FIN:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) op <= op_dec;
  end

  assign dcmd.rd     = fire;
  assign dcmd.link   = (state == S_LINK);
  assign dcmd.commit = commit;
  assign dcmd.op     = op;

  // A commit always presents a result on the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid) else $error("result not presented after commit");

  // A pending result that is not taken blocks the commit
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !commit) else $error("result overwritten");

  // Link phase only follows an accepted transaction
  a_link_after_fire: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> $past(fire)) else $error("link phase without transaction");

endmodule

`default_nettype wire

// ===== rtl/clce_dp.sv =====
// Datapath: link, payload and free stack memories, allocator, cursor and result registers.
`default_nettype none

module clce_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clce_pkg::dp_cmd_t dcmd,
  output clce_pkg::dp_stat_t     stat,
  input  wire clce_pkg::word_t   word_in,
  output clce_pkg::word_t        current_word,
  output logic                   list_empty,
  output clce_pkg::status_t      status,
  output clce_pkg::cnt_t         entry_count
);
  import clce_pkg::*;

  // Node pool memories
  node_t next_link     [NODES];
  node_t prev_link     [NODES];
  word_t payload_store [NODES];
  node_t free_stack    [NODES];

  // Control state
  cnt_t  free_depth, free_depth_next;
  cnt_t  fresh_next, fresh_next_next;
  node_t cursor_node, cursor_node_next;
  node_t head_node, head_node_next;
  cnt_t  node_total, node_total_next;

  // Payload registers
  word_t word_reg;
  word_t cursor_word, cursor_word_next;
  node_t next_rd, prev_rd, fs_rd;
  word_t pay_rd;
  status_t status_next;

  cnt_t  fd_dec;
  node_t nn;
  logic  push_ok;

  // Write ports
  logic  next_we, prev_we, pay_we, fs_we;
  node_t next_wa, next_wd, prev_wa, prev_wd;

  assign fd_dec  = free_depth - cnt_t'(1);
  assign nn      = (free_depth != '0) ? fs_rd : fresh_next[NODE_BITS-1:0];
  assign push_ok = (free_depth < cnt_t'(NODES));

  // Status toward the controller
  assign stat.empty     = (node_total == '0);
  assign stat.single    = (node_total == cnt_t'(1));
  assign stat.can_alloc = (node_total < cnt_t'(NODES)) &&
                          ((free_depth != '0) || (fresh_next < cnt_t'(NODES)));

  // Reads at the cursor and free stack top, issued on accept
  always_ff @(posedge clk) begin
    if (dcmd.rd) begin
      next_rd  <= next_link[cursor_node];
      prev_rd  <= prev_link[cursor_node];
      fs_rd    <= free_stack[fd_dec[NODE_BITS-1:0]];
      word_reg <= word_in;
    end
  end

  // Successor payload read during the link phase of a remove
  always_ff @(posedge clk) begin
    if (dcmd.link && dcmd.op == OP_RM_LINK) pay_rd <= payload_store[next_rd];
  end

  // Next link write port
  always_comb begin
    next_we = 1'b0;
    next_wa = nn;
    next_wd = nn;
    if (dcmd.link) begin
      unique case (dcmd.op)
        OP_INS_FIRST: next_we = 1'b1;
        OP_INS_LINK: begin
          next_we = 1'b1;
          next_wd = next_rd;
        end
        OP_RM_LINK: begin
          next_we = 1'b1;
          next_wa = prev_rd;
          next_wd = next_rd;
        end
        default: next_we = 1'b0;
      endcase
    end else if (dcmd.commit && dcmd.op == OP_INS_LINK) begin
      next_we = 1'b1;
      next_wa = cursor_node;
    end
  end

  // Prev link write port
  always_comb begin
    prev_we = 1'b0;
    prev_wa = nn;
    prev_wd = nn;
    if (dcmd.link) begin
      unique case (dcmd.op)
        OP_INS_FIRST: prev_we = 1'b1;
        OP_INS_LINK: begin
          prev_we = 1'b1;
          prev_wd = cursor_node;
        end
        OP_RM_LINK: begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = prev_rd;
        end
        default: prev_we = 1'b0;
      endcase
    end else if (dcmd.commit && dcmd.op == OP_INS_LINK) begin
      prev_we = 1'b1;
      prev_wa = next_rd;
    end
  end

  assign pay_we = dcmd.link && (dcmd.op == OP_INS_FIRST || dcmd.op == OP_INS_LINK);
  assign fs_we  = dcmd.commit && push_ok && (dcmd.op == OP_RM_LAST || dcmd.op == OP_RM_LINK);

  always_ff @(posedge clk) begin
    if (next_we) next_link[next_wa] <= next_wd;
    if (prev_we) prev_link[prev_wa] <= prev_wd;
    if (pay_we)  payload_store[nn] <= word_reg;
    if (fs_we)   free_stack[free_depth[NODE_BITS-1:0]] <= cursor_node;
  end

  // State update at commit
  always_comb begin
    free_depth_next  = free_depth;
    fresh_next_next  = fresh_next;
    cursor_node_next = cursor_node;
    head_node_next   = head_node;
    node_total_next  = node_total;
    cursor_word_next = cursor_word;
    status_next      = ST_DONE;
    unique case (dcmd.op)
      OP_INS_FIRST, OP_INS_LINK: begin
        if (free_depth != '0) free_depth_next = fd_dec;
        else                  fresh_next_next = fresh_next + cnt_t'(1);
        cursor_node_next = nn;
        if (dcmd.op == OP_INS_FIRST) head_node_next = nn;
        node_total_next  = node_total + cnt_t'(1);
        cursor_word_next = word_reg;
      end
      OP_INS_FULL: status_next = ST_FULL;
      OP_RM_EMPTY: status_next = ST_IGNORED;
      OP_RM_LAST: begin
        if (push_ok) free_depth_next = free_depth + cnt_t'(1);
        cursor_node_next = '0;
        head_node_next   = '0;
        node_total_next  = '0;
        status_next      = ST_LAST_OUT;
      end
      OP_RM_LINK: begin
        if (push_ok) free_depth_next = free_depth + cnt_t'(1);
        if (head_node == cursor_node) head_node_next = next_rd;
        cursor_node_next = next_rd;
        node_total_next  = node_total - cnt_t'(1);
        cursor_word_next = pay_rd;
      end
      default: status_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth  <= '0;
      fresh_next  <= '0;
      cursor_node <= '0;
      head_node   <= '0;
      node_total  <= '0;
    end else if (dcmd.commit) begin
      free_depth  <= free_depth_next;
      fresh_next  <= fresh_next_next;
      cursor_node <= cursor_node_next;
      head_node   <= head_node_next;
      node_total  <= node_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (dcmd.commit) begin
      cursor_word  <= cursor_word_next;
      current_word <= (node_total_next == '0) ? '0 : cursor_word_next;
      list_empty   <= (node_total_next == '0);
      status       <= status_next;
      entry_count  <= node_total_next;
    end
  end

  // Every node is either in the list, on the free stack, or never handed out
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, node_total} + {1'b0, free_depth}) == {1'b0, fresh_next})
    else $error("node pool accounting broken");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    node_total <= cnt_t'(NODES)) else $error("list count beyond pool size");

  // A linked remove moves the cursor onto the old successor
  a_cursor_succ: assert property (@(posedge clk) disable iff (rst)
    (dcmd.commit && dcmd.op == OP_RM_LINK) |=> cursor_node == $past(next_rd))
    else $error("cursor not moved to successor");

endmodule

`default_nettype wire

// ===== rtl/circular_list_cursor_engine_unit.sv =====
// A transaction passes through read, link and commit phases; the result register loads at commit,
// and the next transaction is accepted only after that commit. Link, payload and free stack
// memories have one write port each, so linking a new node into a non-empty list is split
// over a link and a commit phase. A pending result that is not taken holds the commit phase.
// Reset (synchronous, active high) empties the list and allocator; memories are not cleared.
// Top level: circular doubly linked list with cursor over a fixed node pool.
`default_nettype none

module circular_list_cursor_engine_unit (
  input  wire logic clk,
  input  wire logic rst,
  clce_in_if.sink   in_ch,
  clce_out_if.source out_ch
);
  import clce_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  clce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .dcmd      (dcmd)
  );

  clce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dcmd         (dcmd),
    .stat         (stat),
    .word_in      (in_ch.word_in),
    .current_word (out_ch.current_word),
    .list_empty   (out_ch.list_empty),
    .status       (out_ch.status),
    .entry_count  (out_ch.entry_count)
  );

endmodule

`default_nettype wire

// ===== tb/circular_list_cursor_engine_unit_tb.sv =====
// Testbench for the circular list cursor engine: self-checking, random traffic and stalls.
`timescale 1ns / 1ps

module circular_list_cursor_engine_unit_tb;
  import clce_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int WALK_ITEMS = 1350;

  typedef struct packed {
    word_t   word;
    logic    empty;
    status_t status;
    cnt_t    count;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clce_in_if  in_ch ();
  clce_out_if out_ch ();

  circular_list_cursor_engine_unit dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow list: node pool, allocator and cursor
  node_t       link_fwd  [NODES];
  node_t       link_back [NODES];
  word_t       node_word [NODES];
  node_t       spare_node[NODES];
  int unsigned spare_cnt  = 0;
  int unsigned fresh_idx  = 0;
  int unsigned live_nodes = 0;
  node_t       cursor_at  = '0;
  node_t       head_at    = '0;

  cursor_report_t due_reports[$];
  int             err_total  = 0;
  logic           gaps_on    = 1'b0;
  logic           stalls_on  = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one command to the shadow list and return the report it should produce
  function automatic cursor_report_t advance_list(logic op, word_t w);
    cursor_report_t r;
    node_t          nn;
    node_t          a;
    node_t          b;
    logic           got;
    r.status = ST_DONE;
    got      = 1'b0;
    if (op == CMD_INSERT) begin
      // freed nodes first, then never-used ones
      if (live_nodes < NODES) begin
        if (spare_cnt > 0) begin
          spare_cnt--;
          nn  = spare_node[spare_cnt];
          got = 1'b1;
        end else if (fresh_idx < NODES) begin
          nn  = node_t'(fresh_idx);
          fresh_idx++;
          got = 1'b1;
        end
      end
      if (!got) begin
        r.status = ST_FULL;
      end else begin
        node_word[nn] = w;
        if (live_nodes == 0) begin
          link_fwd[nn]  = nn;
          link_back[nn] = nn;
          head_at       = nn;
        end else begin
          a              = link_fwd[cursor_at];
          link_fwd[nn]   = a;
          link_back[nn]  = cursor_at;
          link_back[a]   = nn;
          link_fwd[cursor_at] = nn;
        end
        cursor_at = nn;
        live_nodes++;
      end
    end else if (live_nodes == 0) begin
      r.status = ST_IGNORED;
    end else if (live_nodes == 1) begin
      spare_node[spare_cnt] = cursor_at;
      spare_cnt++;
      cursor_at  = '0;
      head_at    = '0;
      live_nodes = 0;
      r.status   = ST_LAST_OUT;
    end else begin
      // unlink cursor node, cursor moves to its successor
      b = link_back[cursor_at];
      a = link_fwd[cursor_at];
      link_fwd[b]  = a;
      link_back[a] = b;
      if (head_at == cursor_at) head_at = a;
      if (spare_cnt < NODES) begin
        spare_node[spare_cnt] = cursor_at;
        spare_cnt++;
      end
      cursor_at = a;
      live_nodes--;
    end
    r.word  = (live_nodes == 0) ? '0 : node_word[cursor_at];
    r.empty = (live_nodes == 0);
    r.count = cnt_t'(live_nodes);
    return r;
  endfunction

  function automatic int gap_length(logic enabled);
    int pick;
    pick = $urandom_range(0, 99);
    if (!enabled || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Edge-heavy payload mix
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
      3:       w = ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
      default: w = word_t'($urandom);
    endcase
    return w;
  endfunction

  // Drive one command transaction; prediction is taken at the accepting edge
  task automatic send_item(input logic op, input word_t w);
    repeat (gap_length(gaps_on)) @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.cmd     = op;
    in_ch.word_in = w;
    do @(posedge clk); while (!in_ch.ready);
    due_reports.push_back(advance_list(op, w));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Returns on a falling edge so the next drive stays off the sampling edge
  task automatic wait_drained();
    while (due_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Empty list handling, wrap of the cursor, head removal, free node reuse
  task automatic test_empty_list_edges();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_item(CMD_REMOVE, 32'hDEAD_BEEF);
    send_item(CMD_INSERT, '0);
    send_item(CMD_REMOVE, '1);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_INSERT, '1);
    send_item(CMD_INSERT, 32'h8000_0001);
    send_item(CMD_INSERT, 32'h7FFF_FFFE);
    send_item(CMD_REMOVE, '0);  // cursor wraps to head
    send_item(CMD_REMOVE, '0);  // head node removed
    send_item(CMD_INSERT, 32'h5A5A_A5A5);
    send_item(CMD_INSERT, 32'h0000_0001);
    repeat (3) send_item(CMD_REMOVE, '0);
    send_item(CMD_REMOVE, '1);
    send_item(CMD_INSERT, 32'hFFFF_FFFE);
  endtask

  // Fill the pool, then push past it
  task automatic test_pool_full();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    while (live_nodes < NODES / 2) send_item(CMD_INSERT, pick_word());
    wait_drained();  // hold the sender until the result side catches up
    while (live_nodes < NODES) send_item(CMD_INSERT, pick_word());
    repeat (3) send_item(CMD_INSERT, pick_word());
    send_item(CMD_REMOVE, pick_word());
    send_item(CMD_INSERT, pick_word());
    send_item(CMD_INSERT, pick_word());
  endtask

  // Remove everything; first half back to back
  task automatic test_drain();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (live_nodes > NODES / 2) send_item(CMD_REMOVE, pick_word());
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    while (live_nodes > 0) send_item(CMD_REMOVE, pick_word());
    repeat (2) send_item(CMD_REMOVE, pick_word());
  endtask

  // Segments with different insert bias and idling
  task automatic test_random_walk();
    int   done_cnt;
    int   seg_left;
    int   ins_pct;
    logic op;
    done_cnt = 0;
    seg_left = 0;
    ins_pct  = 50;
    while (done_cnt < WALK_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(80, 200);
        case ($urandom_range(0, 3))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          2:       ins_pct = 75;
          default: ins_pct = 95;
        endcase
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (live_nodes == 0)
        op = ($urandom_range(0, 9) == 0) ? CMD_REMOVE : CMD_INSERT;
      else
        op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
      // removes on an empty list are ignored by the block; not counted
      if (!(op == CMD_REMOVE && live_nodes == 0)) done_cnt++;
      send_item(op, pick_word());
      seg_left--;
    end
  endtask

  // Result side back-pressure
  initial begin : result_stalls
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 99) < 25) stall_left = gap_length(1'b1);
      end
    end
  end

  // Compare each result transaction with the oldest expected report
  always @(posedge clk) begin : check_results
    cursor_report_t got;
    cursor_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.current_word, out_ch.list_empty, out_ch.status, out_ch.entry_count};
      if (due_reports.size() == 0) begin
        err_total++;
        if (err_total <= 10)
          $display("unexpected result: word %h empty %0b status %0d count %0d",
                   got.word, got.empty, got.status, got.count);
      end else begin
        want = due_reports.pop_front();
        if (got !== want) begin
          err_total++;
          if (err_total <= 10)
            $display({"result mismatch: expected word %h empty %0b status %0d count %0d,",
                      " got word %h empty %0b status %0d count %0d"},
                     want.word, want.empty, want.status, want.count,
                     got.word, got.empty, got.status, got.count);
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst == 1'b0);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("circular_list_cursor_engine_unit_tb: errors");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_INSERT;
    in_ch.word_in = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_empty_list_edges();
    test_pool_full();
    test_drain();
    test_random_walk();

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_total == 0 && due_reports.size() == 0) begin
      $display("circular_list_cursor_engine_unit_tb: clean");
    end else begin
      $display("circular_list_cursor_engine_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== circular_list_cursor_engine_unit.f =====
rtl/clce_pkg.sv
rtl/clce_if.sv
rtl/clce_ctrl.sv
rtl/clce_dp.sv
rtl/circular_list_cursor_engine_unit.sv
tb/circular_list_cursor_engine_unit_tb.sv
